>>> hdl/pm_pkg.sv
`default_nettype none
package pm_pkg;

  // Defaults of the top-level parameters.
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Field widths.
  localparam int IVL_W      = 32;
  localparam int PPU_W      = 16;
  localparam int DEN_W      = IVL_W + PPU_W;
  localparam int RATE_W     = 58;
  localparam int TOTAL_W    = 64;
  localparam int INIT_W     = 48;
  localparam int DEB_W      = 20;
  localparam int TOF_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Rate constants: 3.6e12 for power in W, 1e6 for flow.
  localparam int K_W = 42;
  localparam logic [K_W-1:0] K_WATT  = K_W'(64'd3600000000000);
  localparam logic [K_W-1:0] K_WATER = K_W'(64'd1000000);

  // Divider step counter width, enough for the widest quotient.
  localparam int STEP_W = 7;

  // Register reset values.
  localparam logic [PPU_W-1:0] PPU_RST = PPU_W'(1000);
  localparam logic [DEB_W-1:0] DEB_RST = DEB_W'(200000);
  localparam logic [TOF_W-1:0] TOF_RST = TOF_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_EDGE    = 3'd0,
    CFG_PULSES_PER_UNIT = 3'd1,
    CFG_METER_KIND      = 3'd2,
    CFG_INITIAL_TOTAL   = 3'd3,
    CFG_DEBOUNCE_US     = 3'd4,
    CFG_ZERO_TIMEOUT    = 3'd5
  } cfg_idx_t;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_WATT  = 1'b0;
  localparam logic KIND_WATER = 1'b1;

  typedef struct packed {
    logic              trigger_edge;
    logic [PPU_W-1:0]  pulses_per_unit;
    logic              meter_kind;
    logic [INIT_W-1:0] initial_total;
    logic [DEB_W-1:0]  debounce_us;
    logic [TOF_W-1:0]  zero_timeout_factor;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

endpackage
`default_nettype wire

>>> hdl/pm_if.sv
`default_nettype none
interface pm_in_if import pm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic             edge_req;
  logic [IVL_W-1:0] interval_us;

  modport source (output valid, op, edge_req, interval_us, input ready);
  modport sink   (input valid, op, edge_req, interval_us, output ready);
endinterface

interface pm_out_if import pm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [RATE_W-1:0]  rate_value;
  logic               rate_unknown;
  logic [TOTAL_W-1:0] total_value;
  logic [IVL_W-1:0]   pulse_count;

  modport source (output valid, accepted, rate_value, rate_unknown, total_value,
                  pulse_count, input ready);
  modport sink   (input valid, accepted, rate_value, rate_unknown, total_value,
                  pulse_count, output ready);
endinterface

interface pm_cfg_if import pm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/pulse_meter_rate_total.sv
// Channel  Dir  Handshake      Word
// in_ch    in   valid/ready    op, edge_req, interval_us
// out_ch   out  valid/ready    accepted, rate_value, rate_unknown, total_value,
//                              pulse_count
// cfg_ch   in   valid/ready    index, data (always ready)
//
// One item at a time; in_ch.ready is high only while the sequencer is idle.
// A counted pulse passes through the bit-serial divider for the total, and
// first for the rate unless its interval is zero. A tick goes through the
// divider only when it recomputes the rate; an edge that is not counted goes
// straight to the output register.
// The result sits in an output register, so in_ch can take the next word
// while out_ch is stalled; the sequencer then waits before the hand-over.
// rst_n is synchronous and clears the counters, rate, total and handshakes.
`default_nettype none
module pulse_meter_rate_total import pm_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pm_in_if.sink     in_ch,
  pm_out_if.source  out_ch,
  pm_cfg_if.sink    cfg_ch
);

  localparam int DW_RATE = K_W + FRAC_BITS;
  localparam int DW_TOT  = COUNT_WIDTH + FRAC_BITS;
  localparam int DW_MAX  = (DW_RATE > DW_TOT) ? DW_RATE : DW_TOT;
  localparam int DIV_W   = (DW_MAX > TOTAL_W) ? DW_MAX : TOTAL_W + 1;
  localparam int CW_EXT  = COUNT_WIDTH + IVL_W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_EVAL  = 10'b0000000010,
    S_MULT  = 10'b0000000100,
    S_CMP   = 10'b0000001000,
    S_MULR  = 10'b0000010000,
    S_RGO   = 10'b0000100000,
    S_RWAIT = 10'b0001000000,
    S_TGO   = 10'b0010000000,
    S_TWAIT = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  cfg_t cfg;

  state_t state_r, state_nxt;
  logic                   op_r, op_nxt;
  logic                   edge_r, edge_nxt;
  logic [IVL_W-1:0]       ivl_r, ivl_nxt;
  logic                   acc_r, acc_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [IVL_W-1:0]       last_r, last_nxt;
  logic [RATE_W-1:0]      rate_r, rate_nxt;
  logic                   unk_r, unk_nxt;
  logic [TOTAL_W-1:0]     total_r, total_nxt;
  logic [DEN_W-1:0]       prod_r, prod_nxt;

  logic                   oval_r, oval_nxt;
  logic                   oacc_r, oacc_nxt;
  logic [RATE_W-1:0]      orate_r, orate_nxt;
  logic                   ounk_r, ounk_nxt;
  logic [TOTAL_W-1:0]     otot_r, otot_nxt;
  logic [IVL_W-1:0]       ocnt_r, ocnt_nxt;

  logic [PPU_W-1:0]       ppu_eff;
  logic [IVL_W-1:0]       mul_a;
  logic [PPU_W-1:0]       mul_b;
  logic [DEN_W-1:0]       mul_p;
  logic [K_W-1:0]         k_sel;
  div_ctl_t               div_ctl;
  logic [DIV_W-1:0]       div_num;
  logic [DEN_W-1:0]       div_den;
  logic                   div_done;
  logic [DIV_W-1:0]       div_quot;
  logic [RATE_W-1:0]      rate_q;
  logic [TOTAL_W-1:0]     tot_q;
  logic [TOTAL_W:0]       tot_sum;
  logic [CW_EXT-1:0]      cnt_wide;
  logic                   counted;

  pm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign ppu_eff = (cfg.pulses_per_unit == '0) ? PPU_W'(1) : cfg.pulses_per_unit;
  assign k_sel   = (cfg.meter_kind == KIND_WATER) ? K_WATER : K_WATT;

  // The one multiplier serves both the timeout bound and the rate divisor.
  assign mul_a = (state_r == S_MULT) ? last_r : ivl_r;
  assign mul_b = (state_r == S_MULT) ? PPU_W'(cfg.zero_timeout_factor) : ppu_eff;
  assign mul_p = DEN_W'(mul_a) * DEN_W'(mul_b);

  assign div_ctl.start = (state_r == S_RGO) || (state_r == S_TGO);
  assign div_ctl.steps = (state_r == S_RGO) ? STEP_W'(DW_RATE) : STEP_W'(DW_TOT);
  assign div_num = (state_r == S_RGO) ? {k_sel, {(DIV_W-K_W){1'b0}}}
                                      : {count_r, {(DIV_W-COUNT_WIDTH){1'b0}}};
  assign div_den = (state_r == S_RGO) ? prod_r : DEN_W'(ppu_eff);

  pm_div #(
    .DIV_W   (DIV_W),
    .DEN_W_P (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign rate_q  = (|div_quot[DIV_W-1:RATE_W]) ? '1 : div_quot[RATE_W-1:0];
  assign tot_q   = (|div_quot[DIV_W-1:TOTAL_W]) ? '1 : div_quot[TOTAL_W-1:0];
  assign tot_sum = {1'b0, tot_q} + (TOTAL_W+1)'(cfg.initial_total);

  assign cnt_wide = CW_EXT'(count_r);
  assign counted  = (edge_r == cfg.trigger_edge) &&
                    !((count_r != '0) && (ivl_r < IVL_W'(cfg.debounce_us)));

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    edge_nxt  = edge_r;
    ivl_nxt   = ivl_r;
    acc_nxt   = acc_r;
    count_nxt = count_r;
    last_nxt  = last_r;
    rate_nxt  = rate_r;
    unk_nxt   = unk_r;
    total_nxt = total_r;
    prod_nxt  = prod_r;
    oval_nxt  = oval_r && !out_ch.ready;
    oacc_nxt  = oacc_r;
    orate_nxt = orate_r;
    ounk_nxt  = ounk_r;
    otot_nxt  = otot_r;
    ocnt_nxt  = ocnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.op;
          edge_nxt  = in_ch.edge_req;
          ivl_nxt   = in_ch.interval_us;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        acc_nxt = 1'b0;
        if (op_r == OP_TICK) begin
          state_nxt = S_MULT;
        end else if (counted) begin
          acc_nxt  = 1'b1;
          last_nxt = ivl_r;
          if (!(&count_r)) begin
            count_nxt = count_r + COUNT_WIDTH'(1);
          end
          if (ivl_r == '0) begin
            rate_nxt  = '0;
            unk_nxt   = 1'b1;
            state_nxt = S_TGO;
          end else begin
            state_nxt = S_MULR;
          end
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_MULT: begin
        prod_nxt  = mul_p;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (DEN_W'(ivl_r) > prod_r) begin
          rate_nxt  = '0;
          unk_nxt   = 1'b0;
          state_nxt = S_OUT;
        end else if (ivl_r > last_r) begin
          state_nxt = S_MULR;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_MULR: begin
        prod_nxt  = mul_p;
        state_nxt = S_RGO;
      end
      S_RGO: begin
        state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        if (div_done) begin
          rate_nxt  = rate_q;
          unk_nxt   = 1'b0;
          state_nxt = acc_r ? S_TGO : S_OUT;
        end
      end
      S_TGO: begin
        state_nxt = S_TWAIT;
      end
      S_TWAIT: begin
        if (div_done) begin
          total_nxt = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hand the word over once the output register is free.
        if (!oval_r || out_ch.ready) begin
          oval_nxt  = 1'b1;
          oacc_nxt  = acc_r;
          orate_nxt = rate_r;
          ounk_nxt  = unk_r;
          otot_nxt  = total_r;
          ocnt_nxt  = cnt_wide[IVL_W-1:0];
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      oval_r  <= 1'b0;
      count_r <= '0;
      last_r  <= '0;
      rate_r  <= '0;
      unk_r   <= 1'b0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
      rate_r  <= rate_nxt;
      unk_r   <= unk_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    edge_r  <= edge_nxt;
    ivl_r   <= ivl_nxt;
    acc_r   <= acc_nxt;
    prod_r  <= prod_nxt;
    oacc_r  <= oacc_nxt;
    orate_r <= orate_nxt;
    ounk_r  <= ounk_nxt;
    otot_r  <= otot_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = oval_r;
  assign out_ch.accepted     = oacc_r;
  assign out_ch.rate_value   = orate_r;
  assign out_ch.rate_unknown = ounk_r;
  assign out_ch.total_value  = otot_r;
  assign out_ch.pulse_count  = ocnt_r;

endmodule
`default_nettype wire

>>> hdl/pm_cfg_regs.sv
`default_nettype none
module pm_cfg_regs import pm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  pm_cfg_if.sink    cfg_ch,
  output cfg_t      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_TRIGGER_EDGE:    cfg_nxt.trigger_edge        = cfg_ch.data[0];
        CFG_PULSES_PER_UNIT: cfg_nxt.pulses_per_unit     = cfg_ch.data[PPU_W-1:0];
        CFG_METER_KIND:      cfg_nxt.meter_kind          = cfg_ch.data[0];
        CFG_INITIAL_TOTAL:   cfg_nxt.initial_total       = cfg_ch.data[INIT_W-1:0];
        CFG_DEBOUNCE_US:     cfg_nxt.debounce_us         = cfg_ch.data[DEB_W-1:0];
        CFG_ZERO_TIMEOUT:    cfg_nxt.zero_timeout_factor = cfg_ch.data[TOF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_edge        <= 1'b0;
      cfg_r.pulses_per_unit     <= PPU_RST;
      cfg_r.meter_kind          <= KIND_WATT;
      cfg_r.initial_total       <= '0;
      cfg_r.debounce_us         <= DEB_RST;
      cfg_r.zero_timeout_factor <= TOF_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/pm_div.sv
`default_nettype none
module pm_div import pm_pkg::*; #(
  parameter int DIV_W = TOTAL_W + 1,
  parameter int DEN_W_P = DEN_W
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire div_ctl_t           ctl,
  input  wire logic [DIV_W-1:0]   num,
  input  wire logic [DEN_W_P-1:0] den,
  output logic                    done,
  output logic [DIV_W-1:0]        quot
);

  // Restoring division, one quotient bit per cycle. The numerator arrives
  // left-aligned, so the step count sets how many of its bits are used.
  logic [DIV_W-1:0]   num_r, num_nxt;
  logic [DIV_W-1:0]   quot_r, quot_nxt;
  logic [DEN_W_P-1:0] den_r, den_nxt;
  logic [DEN_W_P-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DEN_W_P:0]   rem_sh;
  logic [DEN_W_P:0]   rem_sub;
  logic               ge;

  assign rem_sh  = {rem_r, num_r[DIV_W-1]};
  assign rem_sub = rem_sh - (DEN_W_P+1)'(den_r);
  assign ge      = rem_sh >= (DEN_W_P+1)'(den_r);

  always_comb begin
    num_nxt  = num_r;
    quot_nxt = quot_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      num_nxt  = num;
      den_nxt  = den;
      quot_nxt = '0;
      rem_nxt  = '0;
      cnt_nxt  = ctl.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt  = {num_r[DIV_W-2:0], 1'b0};
      quot_nxt = {quot_r[DIV_W-2:0], ge};
      rem_nxt  = ge ? rem_sub[DEN_W_P-1:0] : rem_sh[DEN_W_P-1:0];
      cnt_nxt  = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

>>> hdl/pm_checker.sv
`default_nettype none
module pm_checker import pm_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_accepted,
  input wire logic [RATE_W-1:0]  out_rate_value,
  input wire logic               out_rate_unknown,
  input wire logic [TOTAL_W-1:0] out_total_value,
  input wire logic [IVL_W-1:0]   out_pulse_count
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_rate_value) && $stable(out_total_value))
    else $error("result payload changed while stalled");

  // The block works on one word at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rate_unknown |-> out_rate_value == '0)
    else $error("unknown rate reported with a nonzero value");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_pulse_count != '0)
    else $error("counted pulse reported with a zero count");

endmodule

bind pulse_meter_rate_total pm_checker u_pm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_accepted     (out_ch.accepted),
  .out_rate_value   (out_ch.rate_value),
  .out_rate_unknown (out_ch.rate_unknown),
  .out_total_value  (out_ch.total_value),
  .out_pulse_count  (out_ch.pulse_count)
);
`default_nettype wire

>>> tb/sv/pulse_meter_rate_total_test.sv
`timescale 1ns / 100ps
module pulse_meter_rate_total_test;
  import pm_pkg::*;

  localparam int                FRAC       = FRAC_BITS_DEF;
  localparam logic [63:0]       WATT_K     = 64'd3600000000000;
  localparam logic [63:0]       WATER_K    = 64'd1000000;
  localparam logic [63:0]       RATE_CAP   = (64'd1 << RATE_W) - 64'd1;
  localparam logic [63:0]       TOTAL_CAP  = '1;
  localparam int                QUIET_MAX  = 4000;
  localparam int                HOLD_LEN   = 600;

  typedef struct packed {
    logic             op;
    logic             edge_req;
    logic [IVL_W-1:0] interval_us;
  } pulse_item_t;

  typedef struct packed {
    logic               accepted;
    logic [RATE_W-1:0]  rate;
    logic               unknown;
    logic [TOTAL_W-1:0] total;
    logic [IVL_W-1:0]   count;
  } meter_reading_t;

  logic clk;
  logic rst_n;

  pm_in_if  in_ch ();
  pm_out_if out_ch ();
  pm_cfg_if cfg_ch ();

  pulse_meter_rate_total u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Meter state as the block should hold it.
  cfg_t               m_cfg;
  logic [IVL_W-1:0]   m_count;
  logic [IVL_W-1:0]   m_last_ivl;
  logic [RATE_W-1:0]  m_rate;
  logic               m_unknown;
  logic [TOTAL_W-1:0] m_total;

  pulse_item_t    pulse_q[$];
  meter_reading_t reading_q[$];

  logic        in_taken;
  int          mismatches;
  int          rx_words;
  int          quiet_cycles;
  int          gap_left;
  int          burst_left;
  bit          sender_steady;
  logic [15:0] rx_pat;
  int          hold_left;
  int          next_hold_at;
  logic [31:0] gen_last;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fixed-point quotient with FRAC fraction bits, rounded down and capped.
  function automatic logic [63:0] fixed_quotient(input logic [63:0] num,
                                                 input logic [63:0] den,
                                                 input logic [63:0] cap);
    logic [127:0] q;
    q = ({64'd0, num} << FRAC) / {64'd0, den};
    return (q > {64'd0, cap}) ? cap : q[63:0];
  endfunction

  function automatic logic [RATE_W-1:0] rate_at(input logic [IVL_W-1:0] ivl,
                                                input logic [63:0] ppu);
    logic [63:0] k;
    logic [63:0] q;
    k = (m_cfg.meter_kind == KIND_WATER) ? WATER_K : WATT_K;
    q = fixed_quotient(k, {32'd0, ivl} * ppu, RATE_CAP);
    return q[RATE_W-1:0];
  endfunction

  task automatic meter_step(input pulse_item_t it, output meter_reading_t r);
    logic [63:0] ppu;
    logic [63:0] span;
    logic [63:0] part;
    logic [64:0] sum;
    logic        counted;
    ppu = (m_cfg.pulses_per_unit == 0) ? 64'd1 : {48'd0, m_cfg.pulses_per_unit};
    span = {56'd0, m_cfg.zero_timeout_factor} * {32'd0, m_last_ivl};
    counted = 1'b0;
    if (it.op == OP_EDGE) begin
      if (it.edge_req == m_cfg.trigger_edge &&
          !(m_count != 0 && it.interval_us < {12'd0, m_cfg.debounce_us})) begin
        counted = 1'b1;
        if (m_count != '1) m_count = m_count + 1'b1;
        m_last_ivl = it.interval_us;
        if (it.interval_us == 0) begin
          m_rate = '0;
          m_unknown = 1'b1;
        end else begin
          m_rate = rate_at(it.interval_us, ppu);
          m_unknown = 1'b0;
        end
        part = fixed_quotient({32'd0, m_count}, ppu, TOTAL_CAP);
        sum = {1'b0, part} + {17'd0, m_cfg.initial_total};
        m_total = sum[64] ? TOTAL_CAP : sum[63:0];
      end
    end else if ({32'd0, it.interval_us} > span) begin
      m_rate = '0;
      m_unknown = 1'b0;
    end else if (it.interval_us > m_last_ivl) begin
      m_rate = rate_at(it.interval_us, ppu);
      m_unknown = 1'b0;
    end
    r.accepted = counted;
    r.rate = m_rate;
    r.unknown = m_unknown;
    r.total = m_total;
    r.count = m_count;
  endtask

  task automatic store_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
    case (cfg_idx_t'(idx))
      CFG_TRIGGER_EDGE:    m_cfg.trigger_edge = data[0];
      CFG_PULSES_PER_UNIT: m_cfg.pulses_per_unit = data[PPU_W-1:0];
      CFG_METER_KIND:      m_cfg.meter_kind = data[0];
      CFG_INITIAL_TOTAL:   m_cfg.initial_total = data[INIT_W-1:0];
      CFG_DEBOUNCE_US:     m_cfg.debounce_us = data[DEB_W-1:0];
      CFG_ZERO_TIMEOUT:    m_cfg.zero_timeout_factor = data[TOF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < 40) begin
      $display("mismatch on %s at word %0d: got %0h, expected %0h", what, rx_words, got, want);
    end
    mismatches++;
  endtask

  // Sender: bursts of words with random gaps, fed from pulse_q.
  always @(negedge clk) begin : sender
    pulse_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 1;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0 && !sender_steady) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pulse_q.size() > 0) begin
        nxt = pulse_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.op <= nxt.op;
        in_ch.edge_req <= nxt.edge_req;
        in_ch.interval_us <= nxt.interval_us;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 160)
                                                  : $urandom_range(0, 4);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: rotating stall pattern, plus a long hold now and then while
  // the sender still has words to offer.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_left == 0 && rx_words >= next_hold_at && pulse_q.size() > 8) begin
        hold_left = HOLD_LEN;
        next_hold_at = next_hold_at + 900;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rx_pat[0];
        rx_pat = {rx_pat[0], rx_pat[15:1]};
      end
    end
  end

  always @(posedge clk) begin : monitor
    meter_reading_t want;
    meter_reading_t got;
    pulse_item_t    seen;
    logic           fired;
    if (!rst_n) begin
      in_taken <= 1'b0;
      quiet_cycles = 0;
    end else begin
      fired = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        fired = 1'b1;
        store_setting(cfg_ch.index, cfg_ch.data);
      end
      if (out_ch.valid && out_ch.ready) begin
        fired = 1'b1;
        rx_words++;
        got.accepted = out_ch.accepted;
        got.rate = out_ch.rate_value;
        got.unknown = out_ch.rate_unknown;
        got.total = out_ch.total_value;
        got.count = out_ch.pulse_count;
        if (reading_q.size() == 0) begin
          flag_mismatch("unexpected word", 64'd0, 64'd0);
        end else begin
          want = reading_q.pop_front();
          if (got.accepted !== want.accepted)
            flag_mismatch("accepted", {63'd0, got.accepted}, {63'd0, want.accepted});
          if (got.rate !== want.rate)
            flag_mismatch("rate_value", {6'd0, got.rate}, {6'd0, want.rate});
          if (got.unknown !== want.unknown)
            flag_mismatch("rate_unknown", {63'd0, got.unknown}, {63'd0, want.unknown});
          if (got.total !== want.total)
            flag_mismatch("total_value", got.total, want.total);
          if (got.count !== want.count)
            flag_mismatch("pulse_count", {32'd0, got.count}, {32'd0, want.count});
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        fired = 1'b1;
        seen.op = in_ch.op;
        seen.edge_req = in_ch.edge_req;
        seen.interval_us = in_ch.interval_us;
        meter_step(seen, want);
        reading_q = {reading_q, want};
        in_taken <= 1'b1;
      end else begin
        in_taken <= 1'b0;
      end
      if (fired) begin
        quiet_cycles = 0;
      end else if (pulse_q.size() != 0 || reading_q.size() != 0 || in_ch.valid ||
                   cfg_ch.valid) begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_MAX) begin
        $display("FAIL pulse_meter_rate_total");
        $finish;
      end
    end
  end

  task automatic push_item(input logic op, input logic edge_req, input logic [31:0] ivl);
    pulse_item_t it;
    it.op = op;
    it.edge_req = edge_req;
    it.interval_us = ivl;
    pulse_q = {pulse_q, it};
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic trig, input logic [15:0] ppu, input logic kind,
                                input logic [47:0] init, input logic [19:0] deb,
                                input logic [7:0] tof);
    write_reg(CFG_TRIGGER_EDGE, {47'd0, trig});
    write_reg(CFG_PULSES_PER_UNIT, {32'd0, ppu});
    write_reg(CFG_METER_KIND, {47'd0, kind});
    write_reg(CFG_INITIAL_TOTAL, init);
    write_reg(CFG_DEBOUNCE_US, {28'd0, deb});
    write_reg(CFG_ZERO_TIMEOUT, {40'd0, tof});
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pulse_q.size() != 0 || reading_q.size() != 0 || in_ch.valid) @(negedge clk);
  endtask

  function automatic logic [31:0] clamp32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // Mostly well-formed meter traffic: counted pulses and ticks placed around
  // the last counted interval, with bounces, wrong edges and noise mixed in.
  task automatic queue_random(input int n);
    pulse_item_t it;
    int unsigned pick;
    logic [63:0] span;
    logic [31:0] deb;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      deb = {12'd0, m_cfg.debounce_us};
      span = {56'd0, m_cfg.zero_timeout_factor} * {32'd0, gen_last};
      it.op = OP_EDGE;
      it.edge_req = m_cfg.trigger_edge;
      it.interval_us = '0;
      if (pick < 46) begin
        it.interval_us = (deb == 0) ? $urandom_range(1, 400000)
                                    : deb + $urandom_range(0, 3 * deb);
      end else if (pick < 54) begin
        it.edge_req = ~m_cfg.trigger_edge;
        it.interval_us = $urandom_range(0, 1500000);
      end else if (pick < 62) begin
        it.interval_us = (deb == 0) ? 32'd0 : $urandom_range(0, deb - 1);
      end else if (pick < 65) begin
        it.interval_us = '0;
      end else if (pick < 79) begin
        it.op = OP_TICK;
        it.interval_us = (span > {32'd0, gen_last} && gen_last != 32'hFFFF_FFFF)
                         ? $urandom_range(gen_last + 1, clamp32(span)) : gen_last;
      end else if (pick < 85) begin
        it.op = OP_TICK;
        it.interval_us = $urandom_range(0, gen_last);
      end else if (pick < 92) begin
        it.op = OP_TICK;
        it.interval_us = clamp32(span + 64'd1 + {32'd0, $urandom_range(0, 5000)});
      end else begin
        it.op = $urandom_range(0, 1);
        it.edge_req = $urandom_range(0, 1);
        it.interval_us = $urandom;
      end
      if (it.op == OP_EDGE && it.edge_req == m_cfg.trigger_edge && it.interval_us >= deb)
        gen_last = it.interval_us;
      pulse_q = {pulse_q, it};
    end
  endtask

  initial begin
    logic [15:0] ppu_v;
    logic [47:0] init_v;
    logic [19:0] deb_v;
    logic [7:0]  tof_v;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_EDGE;
    in_ch.edge_req = 1'b0;
    in_ch.interval_us = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_TRIGGER_EDGE;
    cfg_ch.data = '0;
    m_cfg.trigger_edge = 1'b0;
    m_cfg.pulses_per_unit = 16'd1000;
    m_cfg.meter_kind = KIND_WATT;
    m_cfg.initial_total = '0;
    m_cfg.debounce_us = 20'd200000;
    m_cfg.zero_timeout_factor = 8'd100;
    m_count = '0;
    m_last_ivl = '0;
    m_rate = '0;
    m_unknown = 1'b0;
    m_total = '0;
    in_taken = 1'b0;
    mismatches = 0;
    rx_words = 0;
    quiet_cycles = 0;
    sender_steady = 1'b0;
    rx_pat = 16'hFFFF;
    hold_left = 0;
    next_hold_at = 300;
    gen_last = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 10; ph++) begin
      // The sender stays quiet here until every word of the last phase is back.
      wait_idle();
      @(posedge clk);
      rx_pat = (ph % 3 == 1) ? 16'hFFFF : ($urandom | 16'h0001);
      sender_steady = (ph % 4 == 2);
      case (ph)
        0: begin
          // Reset settings: first pulse ignores the debounce, then bounces,
          // wrong edges, the debounce boundary and every tick region.
          push_item(OP_EDGE, 1'b0, 32'd5);
          push_item(OP_TICK, 1'b0, 32'd0);
          push_item(OP_EDGE, 1'b1, 32'd300000);
          push_item(OP_EDGE, 1'b0, 32'd100);
          push_item(OP_EDGE, 1'b0, 32'd199999);
          push_item(OP_EDGE, 1'b0, 32'd200000);
          push_item(OP_TICK, 1'b1, 32'd200000);
          push_item(OP_TICK, 1'b0, 32'd200001);
          push_item(OP_TICK, 1'b0, 32'd20000000);
          push_item(OP_TICK, 1'b0, 32'd20000001);
          push_item(OP_EDGE, 1'b0, 32'hFFFF_FFFF);
          push_item(OP_TICK, 1'b0, 32'hFFFF_FFFF);
          push_item(OP_EDGE, 1'b0, 32'd0);
          gen_last = 32'hFFFF_FFFF;
        end
        1: begin
          apply_settings(1'b1, 16'd1, KIND_WATER, 48'd0, 20'd0, 8'd1);
          // With no debounce a zero interval is counted and leaves the rate
          // unknown until a tick or a pulse clears it.
          push_item(OP_EDGE, 1'b1, 32'd0);
          push_item(OP_TICK, 1'b0, 32'd0);
          push_item(OP_TICK, 1'b1, 32'd1);
          push_item(OP_EDGE, 1'b1, 32'd0);
          push_item(OP_EDGE, 1'b0, 32'd0);
          push_item(OP_EDGE, 1'b1, 32'd1);
          push_item(OP_TICK, 1'b0, 32'd2);
          gen_last = 32'd1;
        end
        2: apply_settings(1'b0, 16'd65535, KIND_WATT, 48'hFFFF_FFFF_FFFF, 20'd1000000,
                          8'd255);
        3: apply_settings(1'b1, 16'd0, KIND_WATT, {$urandom, $urandom}, 20'd50, 8'd1);
        default: begin
          case ($urandom_range(0, 3))
            0: ppu_v = 16'd1;
            1: ppu_v = 16'd65535;
            2: ppu_v = 16'd0;
            default: ppu_v = $urandom_range(1, 65535);
          endcase
          case ($urandom_range(0, 2))
            0: init_v = '0;
            1: init_v = '1;
            default: init_v = {$urandom, $urandom};
          endcase
          case ($urandom_range(0, 3))
            0: deb_v = '0;
            1: deb_v = $urandom_range(1, 100);
            2: deb_v = 20'd1000000;
            default: deb_v = $urandom_range(0, 1000000);
          endcase
          case ($urandom_range(0, 2))
            0: tof_v = 8'd1;
            1: tof_v = 8'd255;
            default: tof_v = $urandom_range(1, 255);
          endcase
          apply_settings($urandom_range(0, 1), ppu_v, $urandom_range(0, 1), init_v,
                         deb_v, tof_v);
        end
      endcase
      if (ph > 0) queue_random(210);
    end

    wait_idle();
    repeat (150) @(posedge clk);
    if (reading_q.size() != 0) flag_mismatch("missing words", reading_q.size(), 64'd0);
    if (mismatches == 0) begin
      $display("PASS pulse_meter_rate_total");
    end else begin
      $display("FAIL pulse_meter_rate_total");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/pm_pkg.sv
hdl/pm_if.sv
hdl/pm_cfg_regs.sv
hdl/pm_div.sv
hdl/pulse_meter_rate_total.sv
hdl/pm_checker.sv
tb/sv/pulse_meter_rate_total_test.sv
